// File: hw/rtl/d2ell_pkg.sv
// Shared types and codes for the dense-to-ELL converter.
// No dependencies; used by the result stage and the top level.
`default_nettype none

package d2ell_pkg;

  // Fixed field widths of the item and configuration ports
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int SLOT_W    = 6;
  localparam int ROW_W     = 6;
  localparam int COLOUT_W  = 6;
  localparam int VALUE_W   = 64;
  localparam int WIDEST_W  = 7;
  localparam int STATUS_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LAST      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  // Control carried from the accept stage to the result stage
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                lookup;     // read that may hit a stored entry
    logic                row_valid;  // row count entry written this load
    logic [SLOT_W-1:0]   slot;
    logic [WIDEST_W-1:0] widest;
  } d2ell_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/d2ell_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module d2ell_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/d2ell_result.sv
// Result stage: forms the ELL read answer from memory read data and registers it.
// Depends on d2ell_pkg (control struct, status codes, field widths).
`default_nettype none

module d2ell_result #(
  parameter int CNT_W = 7,
  parameter int COL_W = 6
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire d2ell_pkg::d2ell_ctl_t            ctl,
  input  wire logic [CNT_W-1:0]                 row_cnt,
  input  wire logic [COL_W-1:0]                 col_data,
  input  wire logic [d2ell_pkg::VALUE_W-1:0]    val_data,
  output      logic                             result_valid,
  output      logic [d2ell_pkg::STATUS_W-1:0]   status,
  output      logic [d2ell_pkg::WIDEST_W-1:0]   widest_row,
  output      logic [d2ell_pkg::COLOUT_W-1:0]   entry_column,
  output      logic [d2ell_pkg::VALUE_W-1:0]    entry_value
);

  localparam int CMP_W = (CNT_W > d2ell_pkg::SLOT_W) ? CNT_W : d2ell_pkg::SLOT_W;

  logic hit;

  // stored entry when the slot lies below the row's count, padding otherwise
  assign hit = ctl.lookup && ctl.row_valid && (CMP_W'(ctl.slot) < CMP_W'(row_cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    status       <= ctl.status;
    widest_row   <= ctl.widest;
    entry_column <= hit ? d2ell_pkg::COLOUT_W'(col_data) : '0;
    entry_value  <= hit ? val_data : '0;
  end

endmodule

`default_nettype wire

// File: hw/rtl/dense_to_ell_converter.sv
// Top level of the dense-to-ELL converter: load tracking, row counts, entry stores.
// Depends on d2ell_pkg, d2ell_ram and d2ell_result.
`default_nettype none

// Takes one item per clock (busy stays low) and returns exactly one result per
// item, marked by result_valid for a single cycle; results leave in item order and
// cannot be held off. Each result passes the accept-stage register, together with
// the registered read of the entry and row-count memories, and then the result
// register, in that order. A load item (kind 0) is the next dense element
// in row-major order; the element at row 0, column 0 begins a new load. Read items
// (kind 1) return ELL entry (read_row, read_slot) once a load has finished.
// Row counts are cleared by per-row valid bits, so there is no clearing pass after
// reset. Write row_count and column_count only while no item is in flight; any
// such write abandons the current load.
module dense_to_ell_converter #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output      logic                                  busy,
  input  wire logic                                  kind,
  input  wire logic [d2ell_pkg::VALUE_W-1:0]         element,
  input  wire logic [d2ell_pkg::ROW_W-1:0]           read_row,
  input  wire logic [d2ell_pkg::SLOT_W-1:0]          read_slot,
  input  wire logic                                  cfg_write,
  input  wire logic [d2ell_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [d2ell_pkg::CFG_W-1:0]           cfg_data,
  output      logic                                  result_valid,
  output      logic [d2ell_pkg::STATUS_W-1:0]        status,
  output      logic [d2ell_pkg::WIDEST_W-1:0]        widest_row,
  output      logic [d2ell_pkg::COLOUT_W-1:0]        entry_column,
  output      logic [d2ell_pkg::VALUE_W-1:0]         entry_value
);

  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RDW   = ($clog2(MAX_ROWS + 1) > d2ell_pkg::CFG_W) ?
                         $clog2(MAX_ROWS + 1) : d2ell_pkg::CFG_W;
  localparam int CDW   = ($clog2(MAX_COLS + 1) > d2ell_pkg::CFG_W) ?
                         $clog2(MAX_COLS + 1) : d2ell_pkg::CFG_W;
  localparam int SCW   = (CNW > d2ell_pkg::SLOT_W) ? CNW : d2ell_pkg::SLOT_W;

  // configuration and load state
  logic [d2ell_pkg::CFG_W-1:0] row_count;
  logic [d2ell_pkg::CFG_W-1:0] column_count;
  logic [RIW-1:0]              row_pos;
  logic [CIW-1:0]              col_pos;
  logic [CNW-1:0]              cur_cnt;
  logic [CNW-1:0]              widest;
  logic                        load_done;
  logic [MAX_ROWS-1:0]         row_valid;

  // accept-stage signals
  logic                  accept;
  logic                  is_load;
  logic [RDW-1:0]        rows;
  logic [CDW-1:0]        cols;
  logic                  at_origin;
  logic                  nonzero;
  logic [CNW-1:0]        cnt_base;
  logic [CNW-1:0]        cnt_inc;
  logic [CNW-1:0]        widest_base;
  logic [CNW-1:0]        widest_next;
  logic                  do_store;
  logic                  col_last;
  logic                  row_last;
  logic                  out_of_range;
  logic [RIW-1:0]        rd_row_idx;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [MAX_ROWS-1:0]   row_valid_next;

  // pipeline register to the result stage
  logic                  s1_valid;
  d2ell_pkg::d2ell_ctl_t ctl_next;
  d2ell_pkg::d2ell_ctl_t s1_ctl;

  // memory read data
  logic [CNW-1:0]                   cnt_rdata;
  logic [CIW-1:0]                   col_rdata;
  logic [d2ell_pkg::VALUE_W-1:0]    val_rdata;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_load = accept && (kind == d2ell_pkg::KIND_LOAD);

  // clamp dimensions to 1..MAX
  always_comb begin
    if (row_count == '0) begin
      rows = RDW'(1);
    end else if (RDW'(row_count) > RDW'(MAX_ROWS)) begin
      rows = RDW'(MAX_ROWS);
    end else begin
      rows = RDW'(row_count);
    end
    if (column_count == '0) begin
      cols = CDW'(1);
    end else if (CDW'(column_count) > CDW'(MAX_COLS)) begin
      cols = CDW'(MAX_COLS);
    end else begin
      cols = CDW'(column_count);
    end
  end

  // load path: position, per-row count, widest row
  assign at_origin   = (row_pos == '0) && (col_pos == '0);
  assign nonzero     = (element[d2ell_pkg::VALUE_W-2:0] != '0);
  assign cnt_base    = (col_pos == '0) ? '0 : cur_cnt;
  assign cnt_inc     = cnt_base + CNW'(1);
  assign widest_base = at_origin ? '0 : widest;
  assign do_store    = is_load && nonzero && (cnt_base < CNW'(MAX_COLS));
  assign col_last    = (CDW'(col_pos) + CDW'(1)) >= cols;
  assign row_last    = (RDW'(row_pos) + RDW'(1)) >= rows;
  assign wr_addr     = AW'(AW'(row_pos) * AW'(MAX_COLS)) + AW'(cnt_base);

  always_comb begin
    if (!is_load) begin
      widest_next = widest;
    end else if (do_store && (cnt_inc > widest_base)) begin
      widest_next = cnt_inc;
    end else begin
      widest_next = widest_base;
    end
  end

  always_comb begin
    row_valid_next = row_valid;
    if (is_load && at_origin) begin
      row_valid_next = '0;
    end
    if (do_store) begin
      row_valid_next[row_pos] = 1'b1;
    end
  end

  // read path: range checks and memory addresses
  assign rd_row_idx   = RIW'(read_row);
  assign rd_addr      = AW'(AW'(read_row) * AW'(MAX_COLS)) + AW'(read_slot);
  assign out_of_range = (RDW'(read_row) >= rows) || (SCW'(read_slot) >= SCW'(widest));

  // control for the result stage
  always_comb begin
    ctl_next.lookup    = 1'b0;
    ctl_next.row_valid = 1'b0;
    ctl_next.slot      = read_slot;
    ctl_next.widest    = d2ell_pkg::WIDEST_W'(widest_next);
    if (kind == d2ell_pkg::KIND_LOAD) begin
      ctl_next.status = (col_last && row_last) ? d2ell_pkg::ST_LAST : d2ell_pkg::ST_OK;
    end else if (!load_done) begin
      ctl_next.status = d2ell_pkg::ST_NOT_READY;
    end else if (out_of_range) begin
      ctl_next.status = d2ell_pkg::ST_RANGE;
    end else begin
      ctl_next.status    = d2ell_pkg::ST_OK;
      ctl_next.lookup    = 1'b1;
      ctl_next.row_valid = row_valid[rd_row_idx];
    end
  end

  // configuration registers and load state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= d2ell_pkg::DIM_RESET;
      column_count <= d2ell_pkg::DIM_RESET;
      row_pos      <= '0;
      col_pos      <= '0;
      cur_cnt      <= '0;
      widest       <= '0;
      load_done    <= 1'b0;
      row_valid    <= '0;
    end else if (cfg_write) begin
      if (cfg_index == d2ell_pkg::REG_ROW_COUNT) begin
        row_count <= cfg_data;
      end else begin
        column_count <= cfg_data;
      end
      row_pos   <= '0;
      col_pos   <= '0;
      cur_cnt   <= '0;
      widest    <= '0;
      load_done <= 1'b0;
      row_valid <= '0;
    end else if (is_load) begin
      cur_cnt   <= do_store ? cnt_inc : cnt_base;
      widest    <= widest_next;
      row_valid <= row_valid_next;
      if (col_last) begin
        col_pos <= '0;
        row_pos <= row_last ? '0 : RIW'(row_pos + 1'b1);
      end else begin
        col_pos <= CIW'(col_pos + 1'b1);
      end
      if (col_last && row_last) begin
        load_done <= 1'b1;
      end else if (at_origin) begin
        load_done <= 1'b0;
      end
    end
  end

  // accept-stage pipeline register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl <= ctl_next;
  end

  // per-row nonzero counts
  d2ell_ram #(
    .WIDTH (CNW),
    .DEPTH (MAX_ROWS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (do_store),
    .waddr (row_pos),
    .wdata (cnt_inc),
    .raddr (rd_row_idx),
    .rdata (cnt_rdata)
  );

  // compacted column indexes
  d2ell_ram #(
    .WIDTH (CIW),
    .DEPTH (DEPTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (do_store),
    .waddr (wr_addr),
    .wdata (col_pos),
    .raddr (rd_addr),
    .rdata (col_rdata)
  );

  // compacted values
  d2ell_ram #(
    .WIDTH (d2ell_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (do_store),
    .waddr (wr_addr),
    .wdata (element),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  // result formation and output register
  d2ell_result #(
    .CNT_W (CNW),
    .COL_W (CIW)
  ) u_result (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s1_valid),
    .ctl          (s1_ctl),
    .row_cnt      (cnt_rdata),
    .col_data     (col_rdata),
    .val_data     (val_rdata),
    .result_valid (result_valid),
    .status       (status),
    .widest_row   (widest_row),
    .entry_column (entry_column),
    .entry_value  (entry_value)
  );

`ifndef SYNTHESIS
  // every result comes from a matching start transfer
  a_result_from_start: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start, 2))
    else $error("result without a matching start transfer");

  // a finished load leaves the position wrapped to the origin
  a_done_at_origin: assert property (@(posedge clk) disable iff (rst)
    load_done |-> (row_pos == '0 && col_pos == '0))
    else $error("load_done set away from the origin");

  // completing a load reports the last-element status on its result
  a_done_reported: assert property (@(posedge clk) disable iff (rst)
    $rose(load_done) |=> (result_valid && status == d2ell_pkg::ST_LAST))
    else $error("load completion not reported");

  // nonzero entry data only on successful reads
  a_entry_only_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (entry_value != '0 || entry_column != '0))
      |-> status == d2ell_pkg::ST_OK)
    else $error("entry data on an error or load result");
`endif

endmodule

`default_nettype wire
